### hw/rtl/tpi_pkg.sv
// Shared widths, hash constants and helpers for the trigram presence indexer.
package tpi_pkg;

	localparam int unsigned BYTE_W          = 8;
	localparam int unsigned FILE_W          = 24;
	localparam int unsigned BUCKET_ID_W     = 16;
	localparam int unsigned HASH_W          = 32;
	localparam int unsigned FILL_W          = 2;

	localparam int unsigned BUCKET_COUNT_DEF = 65536;
	localparam int unsigned WINDOW_LENGTH    = 3;

	localparam logic [HASH_W-1:0] HASH_SEED  = 32'hdeadbeef;
	localparam int unsigned       HASH_MULT  = 109;
	localparam int unsigned       HASH_MULT2 = HASH_MULT * HASH_MULT;
	localparam int unsigned       HASH_MULT3 = HASH_MULT2 * HASH_MULT;

	// Seed pushed through all three multiply steps, folded to one constant
	localparam logic [2*HASH_W-1:0] HASH_BASE_W = 64'(HASH_SEED) * 64'(HASH_MULT3);
	localparam logic [HASH_W-1:0]   HASH_BASE   = HASH_BASE_W[HASH_W-1:0];

	// Window is full once this many prior bytes are held
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_LENGTH - 1);

	// Byte taken as signed char, extended to hash width
	function automatic logic [HASH_W-1:0] sext8(input logic [BYTE_W-1:0] b);
		return {{(HASH_W - BYTE_W){b[BYTE_W-1]}}, b};
	endfunction

endpackage

### hw/rtl/tpi_byte_if.sv
// Input channel: one file byte per word with its file tag and end mark.
interface tpi_byte_if;
	logic                       valid;
	logic                       ready;
	logic [tpi_pkg::BYTE_W-1:0] text_byte;
	logic [tpi_pkg::FILE_W-1:0] file_number;
	logic                       file_end;

	modport source (output valid, text_byte, file_number, file_end, input ready);
	modport sink   (input valid, text_byte, file_number, file_end, output ready);
endinterface

### hw/rtl/tpi_post_if.sv
// Output channel: one posting result word per input byte.
interface tpi_post_if;
	logic                            valid;
	logic                            ready;
	logic                            posting_valid;
	logic [tpi_pkg::BUCKET_ID_W-1:0] bucket_id;
	logic [tpi_pkg::FILE_W-1:0]      posting_file;
	logic                            file_done;

	modport source (output valid, posting_valid, bucket_id, posting_file, file_done,
		input ready);
	modport sink   (input valid, posting_valid, bucket_id, posting_file, file_done,
		output ready);
endinterface

### hw/rtl/trigram_presence_indexer.sv
// Trigram presence indexer: takes one file byte per cycle and returns one result word per
// byte, in input order. The three-byte window of each byte is hashed to a bucket and checked
// against an owner memory of BUCKET_COUNT entries; a posting is flagged the first time the
// current file touches a bucket. Throughput is one byte per cycle, set by the single read and
// single write per cycle of the owner memory; back-to-back hits on the same bucket are
// forwarded. After reset the owner memory is swept to zero, one entry per cycle, and the
// input is held off until the sweep ends. Output backpressure stalls the whole pipeline; a
// byte is still taken in any cycle where the output word is consumed.
module trigram_presence_indexer #(
	parameter int unsigned BUCKET_COUNT = tpi_pkg::BUCKET_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tpi_byte_if.sink   byte_in,
	tpi_post_if.source post_out
);
	import tpi_pkg::*;

	localparam int unsigned BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
	localparam int unsigned RW = BW + 1;
	localparam logic [RW-1:0] BC_RW    = RW'(BUCKET_COUNT);
	localparam logic [BW-1:0] LAST_IDX = BW'(BUCKET_COUNT - 1);
	// floor(2^32 / BUCKET_COUNT): quotient estimate is low by at most one
	localparam logic [2*HASH_W-1:0] RECIP_W = (64'd1 << HASH_W) / 64'(BUCKET_COUNT);
	localparam logic [HASH_W-1:0]   RECIP   = RECIP_W[HASH_W-1:0];

	// Owner memory
	logic [FILE_W-1:0] owner_mem [BUCKET_COUNT];

	// Clear sweep
	logic          clr_busy_q;
	logic [BW-1:0] clr_idx_q;

	// Window state
	logic [BYTE_W-1:0] prior_one_q;
	logic [BYTE_W-1:0] prior_two_q;
	logic [FILL_W-1:0] fill_q;

	// Pipeline
	logic adv;
	logic accept;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic tri_s1, tri_s2, tri_s3, tri_s4;
	logic end_s1, end_s2, end_s3, end_s4;
	logic [FILE_W-1:0] file_s1, file_s2, file_s3, file_s4;
	logic [HASH_W-1:0] h_s1, h_s2;
	logic [HASH_W-1:0] q_s2;
	logic [RW-1:0]     r_s3;
	logic [BW-1:0]     idx_s4;
	logic [FILE_W-1:0] rd_s4;
	logic              fwd_s4;
	logic [FILE_W-1:0] fwd_tag_s4;

	logic [HASH_W-1:0]   hash_c;
	logic [2*HASH_W-1:0] prod_c;
	logic [2*RW-1:0]     qc_c;
	logic [BW-1:0]       idx_c;
	logic [FILE_W-1:0]   tag_c;
	logic [FILE_W-1:0]   owner_c;
	logic                new_post_c;
	logic                wr_en;
	logic [BW-1:0]       wr_idx;
	logic [FILE_W-1:0]   wr_data;

	// Output register
	logic                   out_vld_q;
	logic                   out_pv_q;
	logic [BUCKET_ID_W-1:0] out_bucket_q;
	logic [FILE_W-1:0]      out_file_q;
	logic                   out_done_q;

	// Handshake
	assign adv           = !out_vld_q || post_out.ready;
	assign byte_in.ready = adv && !clr_busy_q;
	assign accept        = byte_in.valid && byte_in.ready;

	// Sweep owner memory to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == LAST_IDX) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Window of the two prior bytes, restarted after an end mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_one_q <= '0;
			prior_two_q <= '0;
			fill_q      <= '0;
		end else if (accept) begin
			if (byte_in.file_end) begin
				prior_one_q <= '0;
				prior_two_q <= '0;
				fill_q      <= '0;
			end else begin
				prior_two_q <= prior_one_q;
				prior_one_q <= byte_in.text_byte;
				if (fill_q != FILL_FULL) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	// Stage 0: hash with the seed folded in; constant multipliers only
	assign hash_c = HASH_BASE
		+ sext8(prior_two_q) * HASH_W'(HASH_MULT2)
		+ sext8(prior_one_q) * HASH_W'(HASH_MULT)
		+ sext8(byte_in.text_byte);

	// Stage 1 -> 2: reciprocal multiply for the bucket quotient
	assign prod_c = h_s1 * RECIP;

	// Stage 2 -> 3: remainder estimate, below twice the bucket count
	assign qc_c = q_s2[RW-1:0] * BC_RW;

	// Stage 3: final correction gives the bucket, which addresses the memory
	assign idx_c = (r_s3 >= BC_RW) ? BW'(r_s3 - BC_RW) : BW'(r_s3);

	// Stage 4: owner compare with forwarding of the previous item's write
	assign tag_c      = file_s4 + 1'b1;
	assign owner_c    = fwd_s4 ? fwd_tag_s4 : rd_s4;
	assign new_post_c = tri_s4 && (owner_c != tag_c);

	// Pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			fwd_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= accept;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			fwd_s4    <= vld_s4 && tri_s4 && vld_s3 && tri_s3 && (idx_s4 == idx_c);
			out_vld_q <= vld_s4;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			tri_s1  <= (fill_q == FILL_FULL);
			end_s1  <= byte_in.file_end;
			file_s1 <= byte_in.file_number;
			h_s1    <= hash_c;

			tri_s2  <= tri_s1;
			end_s2  <= end_s1;
			file_s2 <= file_s1;
			h_s2    <= h_s1;
			q_s2    <= prod_c[2*HASH_W-1:HASH_W];

			tri_s3  <= tri_s2;
			end_s3  <= end_s2;
			file_s3 <= file_s2;
			r_s3    <= h_s2[RW-1:0] - qc_c[RW-1:0];

			tri_s4  <= tri_s3;
			end_s4  <= end_s3;
			file_s4 <= file_s3;
			idx_s4  <= idx_c;
			fwd_tag_s4 <= tag_c;

			out_pv_q     <= new_post_c;
			out_bucket_q <= tri_s4 ? BUCKET_ID_W'(idx_s4) : '0;
			out_file_q   <= new_post_c ? file_s4 : '0;
			out_done_q   <= end_s4;
		end
	end

	// Memory write: sweep first, then owner updates
	assign wr_en   = clr_busy_q || (adv && vld_s4 && new_post_c);
	assign wr_idx  = clr_busy_q ? clr_idx_q : idx_s4;
	assign wr_data = clr_busy_q ? '0 : tag_c;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			owner_mem[wr_idx] <= wr_data;
		end
		if (adv) begin
			rd_s4 <= owner_mem[idx_c];
		end
	end

	// Output word
	assign post_out.valid         = out_vld_q;
	assign post_out.posting_valid = out_pv_q;
	assign post_out.bucket_id     = out_bucket_q;
	assign post_out.posting_file  = out_file_q;
	assign post_out.file_done     = out_done_q;

`ifndef SYNTHESIS
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_in.valid && byte_in.ready) |=> vld_s1)
		else $error("accepted byte did not enter the pipeline");

	a_sweep_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (!vld_s1 && !vld_s4 && !out_vld_q))
		else $error("pipeline busy during memory sweep");

	a_post_needs_window: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && !tri_s4) |-> !new_post_c)
		else $error("posting without a complete trigram");

	a_file_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(post_out.valid && !post_out.posting_valid) |-> (post_out.posting_file == '0))
		else $error("file field set without a posting");
`endif

endmodule
